[src/pgti_pkg.sv]
// Shared constants and types for the periodic grid trilinear interpolator.
package pgti_pkg;

  localparam int MAX_DIM_DEF    = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W    = 32;
  localparam int IDX_W      = 15;
  localparam int DIMF_W     = 6;
  localparam int DIMS_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // grid_dims field positions
  localparam int DIM_X_LSB = 12;
  localparam int DIM_Y_LSB = 6;
  localparam int DIM_Z_LSB = 0;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INV_X    = 3'd0;
  localparam cfg_idx_t REG_INV_Y    = 3'd1;
  localparam cfg_idx_t REG_INV_Z    = 3'd2;
  localparam cfg_idx_t REG_OFF_X    = 3'd3;
  localparam cfg_idx_t REG_OFF_Y    = 3'd4;
  localparam cfg_idx_t REG_OFF_Z    = 3'd5;
  localparam cfg_idx_t REG_DIMS     = 3'd6;
  localparam cfg_idx_t REG_PERIODIC = 3'd7;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_CLAMP   = 2'd1;
  localparam status_t ST_OUTSIDE = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [COORD_W-1:0] INV_RESET  = 32'd65536;
  localparam logic [DIMS_W-1:0]  DIMS_RESET = 18'd133152;

endpackage

[src/periodic_grid_trilinear_interp.sv]
// Top level: grid store, axis mapping, corner fetch and serial trilinear lerps.
//
//  port group | dir | word
//  in_*       | in  | load entry (cmd 0) or query position (cmd 1)
//  out_*      | out | interpolated force, energy and status, one per query
//  cfg_*      | in  | register index and write data, always ready
//
// A load is written to the grid memory as it is taken. A query maps each axis
// through S_DIFF, S_AMUL, S_APOST and S_AMAP (plus remainder and wrap steps per
// axis when periodic), reads the eight corners from the grid memory, and runs
// the 28 lerps, each through S_LDIFF, S_LMUL and S_LADD, on the one shared
// multiplier before it writes the output register. A neighbour-outside query
// skips the fetch and lerps. Reset is synchronous; the grid memory is not
// cleared. A stalled output holds the block in its last step, while the next
// input word is taken once the result is latched.
module periodic_grid_trilinear_interp #(
  parameter int MAX_DIM    = pgti_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = pgti_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = pgti_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [pgti_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [VALUE_BITS-1:0]         in_load_force_x,
  input  logic signed [VALUE_BITS-1:0]         in_load_force_y,
  input  logic signed [VALUE_BITS-1:0]         in_load_force_z,
  input  logic signed [VALUE_BITS-1:0]         in_load_energy,
  input  logic signed [pgti_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pgti_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [pgti_pkg::COORD_W-1:0]  in_pos_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [VALUE_BITS-1:0]         out_force_x,
  output logic signed [VALUE_BITS-1:0]         out_force_y,
  output logic signed [VALUE_BITS-1:0]         out_force_z,
  output logic signed [VALUE_BITS-1:0]         out_energy_out,
  output pgti_pkg::status_t                    out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  pgti_pkg::cfg_idx_t                   cfg_index,
  input  logic [pgti_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW    = pgti_pkg::COORD_W;
  localparam int F     = FRAC_BITS;
  localparam int VB    = VALUE_BITS;
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int XW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (VB + 1 > CW + 1) ? VB + 1 : CW + 1;
  localparam int PW    = 2 * MW;
  localparam int QW    = 2 * CW - F + 2;
  localparam int CMW   = QW - F;
  localparam int MODW  = CMW + 1;
  localparam int MCW   = $clog2(MODW + 1);
  localparam int WW    = 4 * VB;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DIFF  = 12'b0000_0000_0010,
    S_AMUL  = 12'b0000_0000_0100,
    S_APOST = 12'b0000_0000_1000,
    S_AMAP  = 12'b0000_0001_0000,
    S_MOD   = 12'b0000_0010_0000,
    S_WRAP  = 12'b0000_0100_0000,
    S_FETCH = 12'b0000_1000_0000,
    S_LDIFF = 12'b0001_0000_0000,
    S_LMUL  = 12'b0010_0000_0000,
    S_LADD  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  function automatic logic [NW-1:0] dim_fix(input logic [pgti_pkg::DIMF_W-1:0] d);
    if (d == '0) return NW'(1);
    if (int'(d) > MAX_DIM) return NW'(MAX_DIM);
    return NW'(d);
  endfunction

  // control
  state_t state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  pgti_pkg::status_t st_r, st_nxt;
  logic [MCW-1:0] mcnt_r, mcnt_nxt;
  logic [3:0] kcnt_r, kcnt_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic out_valid_r, out_valid_nxt;

  // configuration
  logic [CW-1:0] inv_r [3];
  logic signed [CW-1:0] off_r [3];
  logic [pgti_pkg::DIMS_W-1:0] dims_r;
  logic per_r;

  // datapath
  logic signed [CW-1:0] pos_r [3], pos_nxt [3];
  logic neg_r, neg_nxt;
  logic [CW:0] mag_r, mag_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [MODW-1:0] mod_sh_r, mod_sh_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [XW-1:0] lo_r [3], lo_nxt [3];
  logic [XW-1:0] hi_r [3], hi_nxt [3];
  logic [F-1:0] frac_r [3], frac_nxt [3];
  logic signed [VB-1:0] cq_r [4][8], cq_nxt [4][8];
  logic signed [VB:0] diff_r, diff_nxt;
  logic signed [VB-1:0] la_r, la_nxt;
  logic [F-1:0] lf_r, lf_nxt;
  logic signed [VB-1:0] res_r [4], res_nxt [4];
  logic signed [VB-1:0] ofx_r, ofy_r, ofz_r, oen_r;
  logic signed [VB-1:0] ofx_nxt, ofy_nxt, ofz_nxt, oen_nxt;
  pgti_pkg::status_t ost_r, ost_nxt;

  // memory
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data_r;
  logic mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;

  // combinational helpers
  logic in_acc;
  logic [NW-1:0] n_a [3];
  logic [NW-1:0] n_cur;
  logic signed [CW:0] diff_w;
  logic [CW:0] mag_w;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_w;
  logic [2*CW-1:0] p0;
  logic [CW-1:0] p1;
  logic [QW-1:0] q_w;
  logic [F-1:0] qf;
  logic fracnz;
  logic [CMW-1:0] cm;
  logic [MODW-1:0] m_w;
  logic [NW:0] rem_sh;
  logic [XW-1:0] map_lo, map_hi, wrap_lo, wrap_hi;
  logic [F-1:0] map_f, wrap_f;
  pgti_pkg::status_t map_st, st_upd;
  logic [NW:0] map_inc, wrap_inc;
  logic [2:0] corner;
  logic [XW-1:0] cx, cy, cz;
  logic [AW-1:0] xy;
  logic signed [VB-1:0] ta, tb;
  logic [F-1:0] tf;
  logic signed [PW-1:0] sh;
  logic signed [VB:0] lsum;
  logic signed [VB-1:0] lres;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign n_a[0] = dim_fix(dims_r[pgti_pkg::DIM_X_LSB +: pgti_pkg::DIMF_W]);
  assign n_a[1] = dim_fix(dims_r[pgti_pkg::DIM_Y_LSB +: pgti_pkg::DIMF_W]);
  assign n_a[2] = dim_fix(dims_r[pgti_pkg::DIM_Z_LSB +: pgti_pkg::DIMF_W]);
  assign n_cur  = n_a[ax_r];

  // axis front end
  assign diff_w = {pos_r[ax_r][CW-1], pos_r[ax_r]} - {off_r[ax_r][CW-1], off_r[ax_r]};
  assign mag_w  = diff_w[CW] ? (CW+1)'(-diff_w) : diff_w;

  always_comb begin
    if (state_r == S_AMUL) begin
      mul_a = $signed(MW'(mag_r[CW-1:0]));
      mul_b = $signed(MW'(inv_r[ax_r]));
    end else begin
      mul_a = MW'(diff_r);
      mul_b = $signed(MW'(lf_r));
    end
  end

  pgti_mul #(.W(MW)) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_w)
  );

  // scaled coordinate; a negative one rounds its magnitude up (floor)
  assign p0  = prod_w[2*CW-1:0];
  assign p1  = mag_r[CW] ? inv_r[ax_r] : '0;
  assign q_w = QW'(p0 >> F) + (QW'(p1) << (CW - F)) + QW'(neg_r & (|p0[F-1:0]));

  assign qf     = q_r[F-1:0];
  assign fracnz = |qf;
  assign cm     = q_r[QW-1:F];
  assign m_w    = MODW'(cm) + MODW'(neg_r & fracnz);

  // clamped mapping
  always_comb begin
    map_st = pgti_pkg::ST_OK;
    if (neg_r) begin
      map_lo = '0;
      map_f  = '0;
      if (|q_r) map_st = pgti_pkg::ST_CLAMP;
    end else if (cm >= CMW'(n_cur)) begin
      map_lo = XW'(n_cur - NW'(1));
      map_f  = '0;
      map_st = pgti_pkg::ST_CLAMP;
    end else begin
      map_lo = XW'(cm);
      map_f  = qf;
    end
    map_inc = (NW+1)'(map_lo) + (NW+1)'(1);
    if (map_inc >= (NW+1)'(n_cur)) begin
      map_hi = map_lo;
      map_st = pgti_pkg::ST_OUTSIDE;
    end else begin
      map_hi = XW'(map_inc);
    end
  end

  assign st_upd = (map_st > st_r) ? map_st : st_r;

  // wrapped mapping from the remainder
  assign rem_sh = {rem_r, mod_sh_r[MODW-1]};

  always_comb begin
    if (neg_r && (rem_r != '0)) wrap_lo = XW'(n_cur - rem_r);
    else wrap_lo = XW'(rem_r);
    wrap_inc = (NW+1)'(wrap_lo) + (NW+1)'(1);
    wrap_hi  = (wrap_inc >= (NW+1)'(n_cur)) ? '0 : XW'(wrap_inc);
    if (!neg_r) wrap_f = qf;
    else if (fracnz) wrap_f = (~qf) + F'(1);
    else wrap_f = '0;
  end

  // corner address
  assign corner  = kcnt_r[2:0];
  assign cx      = corner[2] ? hi_r[0] : lo_r[0];
  assign cy      = corner[1] ? hi_r[1] : lo_r[1];
  assign cz      = corner[0] ? hi_r[2] : lo_r[2];
  assign xy      = AW'(cx) * AW'(n_a[1]) + AW'(cy);
  assign rd_addr = xy * AW'(n_a[2]) + AW'(cz);
  assign mem_re  = (state_r == S_FETCH) && !kcnt_r[3];

  assign mem_we  = in_acc && (in_cmd == pgti_pkg::CMD_LOAD) &&
                   (32'(in_entry_index) < 32'(DEPTH));
  assign wr_addr = AW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {in_load_energy, in_load_force_z, in_load_force_y,
                                 in_load_force_x};
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  // lerp operand taps on the active channel queue
  always_comb begin
    if (step_r < 3'd4) begin
      ta = cq_r[0][0];
      tb = cq_r[0][4];
      tf = frac_r[0];
    end else if (step_r < 3'd6) begin
      ta = cq_r[0][4];
      tb = cq_r[0][6];
      tf = frac_r[1];
    end else begin
      ta = cq_r[0][6];
      tb = cq_r[0][7];
      tf = frac_r[2];
    end
  end

  assign sh   = prod_w >>> F;
  assign lsum = {la_r[VB-1], la_r} + sh[VB:0];

  always_comb begin
    if (lsum[VB] != lsum[VB-1]) lres = lsum[VB] ? {1'b1, {(VB-1){1'b0}}}
                                                : {1'b0, {(VB-1){1'b1}}};
    else lres = lsum[VB-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    st_nxt        = st_r;
    mcnt_nxt      = mcnt_r;
    kcnt_nxt      = kcnt_r;
    step_nxt      = step_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    q_nxt         = q_r;
    mod_sh_nxt    = mod_sh_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    frac_nxt      = frac_r;
    cq_nxt        = cq_r;
    diff_nxt      = diff_r;
    la_nxt        = la_r;
    lf_nxt        = lf_r;
    res_nxt       = res_r;
    ofx_nxt       = ofx_r;
    ofy_nxt       = ofy_r;
    ofz_nxt       = ofz_r;
    oen_nxt       = oen_r;
    ost_nxt       = ost_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == pgti_pkg::CMD_QUERY)) begin
          pos_nxt[0] = in_pos_x;
          pos_nxt[1] = in_pos_y;
          pos_nxt[2] = in_pos_z;
          ax_nxt     = '0;
          st_nxt     = pgti_pkg::ST_OK;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        neg_nxt   = diff_w[CW];
        mag_nxt   = mag_w;
        state_nxt = S_AMUL;
      end
      S_AMUL: state_nxt = S_APOST;
      S_APOST: begin
        q_nxt     = q_w;
        state_nxt = S_AMAP;
      end
      S_AMAP: begin
        if (per_r) begin
          mod_sh_nxt = m_w;
          rem_nxt    = '0;
          mcnt_nxt   = '0;
          state_nxt  = S_MOD;
        end else begin
          lo_nxt[ax_r]   = map_lo;
          hi_nxt[ax_r]   = map_hi;
          frac_nxt[ax_r] = map_f;
          st_nxt         = st_upd;
          if (ax_r == 2'd2) begin
            kcnt_nxt  = '0;
            state_nxt = (st_upd == pgti_pkg::ST_OUTSIDE) ? S_OUT : S_FETCH;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = S_DIFF;
          end
        end
      end
      S_MOD: begin
        // one quotient bit per cycle, remainder kept below n
        rem_nxt    = (rem_sh >= (NW+1)'(n_cur)) ? NW'(rem_sh - (NW+1)'(n_cur))
                                                : NW'(rem_sh);
        mod_sh_nxt = mod_sh_r << 1;
        mcnt_nxt   = mcnt_r + MCW'(1);
        if (mcnt_r == MCW'(MODW - 1)) state_nxt = S_WRAP;
      end
      S_WRAP: begin
        lo_nxt[ax_r]   = wrap_lo;
        hi_nxt[ax_r]   = wrap_hi;
        frac_nxt[ax_r] = wrap_f;
        if (ax_r == 2'd2) begin
          kcnt_nxt  = '0;
          state_nxt = S_FETCH;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_DIFF;
        end
      end
      S_FETCH: begin
        if (kcnt_r != '0) begin
          for (int c = 0; c < 4; c++) begin
            for (int s = 0; s < 7; s++) cq_nxt[c][s] = cq_r[c][s+1];
            cq_nxt[c][7] = rd_data_r[c*VB +: VB];
          end
        end
        if (kcnt_r == 4'd8) begin
          step_nxt  = '0;
          ch_nxt    = '0;
          state_nxt = S_LDIFF;
        end else begin
          kcnt_nxt = kcnt_r + 4'd1;
        end
      end
      S_LDIFF: begin
        diff_nxt  = {tb[VB-1], tb} - {ta[VB-1], ta};
        la_nxt    = ta;
        lf_nxt    = tf;
        state_nxt = S_LMUL;
      end
      S_LMUL: state_nxt = S_LADD;
      S_LADD: begin
        if (step_r == 3'd6) begin
          // channel done: rotate the next channel into the working slot
          for (int c = 0; c < 3; c++) begin
            cq_nxt[c]  = cq_r[c+1];
            res_nxt[c] = res_r[c+1];
          end
          cq_nxt[3]  = cq_r[0];
          res_nxt[3] = lres;
          step_nxt   = '0;
          if (ch_r == 2'd3) begin
            state_nxt = S_OUT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_LDIFF;
          end
        end else begin
          for (int s = 0; s < 7; s++) cq_nxt[0][s] = cq_r[0][s+1];
          cq_nxt[0][7] = lres;
          step_nxt     = step_r + 3'd1;
          state_nxt    = S_LDIFF;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          if (st_r == pgti_pkg::ST_OUTSIDE) begin
            ofx_nxt = '0;
            ofy_nxt = '0;
            ofz_nxt = '0;
            oen_nxt = '0;
          end else begin
            ofx_nxt = res_r[0];
            ofy_nxt = res_r[1];
            ofz_nxt = res_r[2];
            oen_nxt = res_r[3];
          end
          ost_nxt       = st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      st_r        <= pgti_pkg::ST_OK;
      mcnt_r      <= '0;
      kcnt_r      <= '0;
      step_r      <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        inv_r[a] <= pgti_pkg::INV_RESET;
        off_r[a] <= '0;
      end
      dims_r <= pgti_pkg::DIMS_RESET;
      per_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      st_r        <= st_nxt;
      mcnt_r      <= mcnt_nxt;
      kcnt_r      <= kcnt_nxt;
      step_r      <= step_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pgti_pkg::REG_INV_X:    inv_r[0] <= cfg_data;
          pgti_pkg::REG_INV_Y:    inv_r[1] <= cfg_data;
          pgti_pkg::REG_INV_Z:    inv_r[2] <= cfg_data;
          pgti_pkg::REG_OFF_X:    off_r[0] <= cfg_data;
          pgti_pkg::REG_OFF_Y:    off_r[1] <= cfg_data;
          pgti_pkg::REG_OFF_Z:    off_r[2] <= cfg_data;
          pgti_pkg::REG_DIMS:     dims_r   <= cfg_data[pgti_pkg::DIMS_W-1:0];
          pgti_pkg::REG_PERIODIC: per_r    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    q_r      <= q_nxt;
    mod_sh_r <= mod_sh_nxt;
    rem_r    <= rem_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    frac_r   <= frac_nxt;
    cq_r     <= cq_nxt;
    diff_r   <= diff_nxt;
    la_r     <= la_nxt;
    lf_r     <= lf_nxt;
    res_r    <= res_nxt;
    ofx_r    <= ofx_nxt;
    ofy_r    <= ofy_nxt;
    ofz_r    <= ofz_nxt;
    oen_r    <= oen_nxt;
    ost_r    <= ost_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_force_x    = ofx_r;
  assign out_force_y    = ofy_r;
  assign out_force_z    = ofz_r;
  assign out_energy_out = oen_r;
  assign out_status     = ost_r;

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pgti_pkg::ST_OUTSIDE) |->
    (out_force_x == '0 && out_force_y == '0 && out_force_z == '0 &&
     out_energy_out == '0))
    else $error("outside status with nonzero result word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == pgti_pkg::ST_OK || out_status == pgti_pkg::ST_CLAMP ||
                   out_status == pgti_pkg::ST_OUTSIDE))
    else $error("undefined status code on result word");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (rem_r < n_cur))
    else $error("wrap remainder not below grid size");

  a_fetch_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (st_r != pgti_pkg::ST_OUTSIDE))
    else $error("corner fetch for a query with neighbour outside");
`endif

endmodule

[src/pgti_mul.sv]
// Shared signed multiplier with a registered product.
module pgti_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   mul_a,
  input  logic signed [W-1:0]   mul_b,
  output logic signed [2*W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

[dv/tb_periodic_grid_trilinear_interp.sv]
// Testbench for the periodic grid trilinear interpolator: directed table plus random traffic.
module tb_periodic_grid_trilinear_interp;

  localparam int NMAX = 32;
  localparam int DEPTH = NMAX * NMAX * NMAX;

  typedef struct {
    logic [31:0]       fx, fy, fz, en;
    pgti_pkg::status_t st;
  } interp_res_t;

  typedef struct {
    logic              cmd;
    logic [14:0]       idx;
    logic [31:0]       lfx, lfy, lfz, len;
    logic [31:0]       px, py, pz;
    logic              has_exp;
    pgti_pkg::status_t exp_st;
  } grid_word_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_cmd;
  logic [pgti_pkg::IDX_W-1:0] in_entry_index;
  logic signed [31:0] in_load_force_x, in_load_force_y, in_load_force_z, in_load_energy;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic out_valid, out_ready;
  logic signed [31:0] out_force_x, out_force_y, out_force_z, out_energy_out;
  pgti_pkg::status_t out_status;
  logic cfg_valid, cfg_ready;
  pgti_pkg::cfg_idx_t cfg_index;
  logic [31:0] cfg_data;

  periodic_grid_trilinear_interp dut (.*);

  // shadow of the block's registers and grid
  logic [31:0] inv_sp[3];
  logic signed [63:0] org[3];
  logic [17:0] dims;
  logic        wrap;
  logic signed [31:0] frc[DEPTH][3];
  logic signed [31:0] eng[DEPTH];
  bit          written[DEPTH];

  interp_res_t pending_q[$];
  int errors, mism, n_res, n_words, n_clamp, n_out;
  int idle_pct;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  function automatic int dim_n(int sh);
    int d;
    d = (dims >> sh) & 63;
    if (d == 0) d = 1;
    if (d > NMAX) d = NMAX;
    return d;
  endfunction

  // maps one axis to lo/hi corner and fraction; returns status
  function automatic int map_coord(logic signed [63:0] diff, logic [31:0] inv, int n,
                                   output int lo, output int hi,
                                   output logic signed [63:0] frac);
    logic signed [127:0] prod;
    logic signed [63:0] t, cidx;
    int st, r;
    st = 0;
    prod = diff * $signed({1'b0, inv});
    t = prod >>> 16;
    cidx = t >>> 16;
    frac = t & 64'hFFFF;
    if (wrap) begin
      r = int'(cidx % n);
      if (r < 0) r += n;
      lo = r;
      hi = (r + 1 >= n) ? 0 : r + 1;
    end else begin
      if (cidx < 0) begin
        cidx = 0; frac = 0; st = 1;
      end else if (cidx >= n) begin
        cidx = n - 1; frac = 0; st = 1;
      end
      lo = int'(cidx);
      hi = lo + 1;
      if (hi >= n) begin
        hi = lo; st = 2;
      end
    end
    return st;
  endfunction

  function automatic logic signed [63:0] lerp(logic signed [63:0] a, b, f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic logic [31:0] trilerp(logic signed [63:0] c[8],
                                          logic signed [63:0] d[3]);
    logic signed [63:0] e00, e01, e10, e11, e0, e1, v;
    e00 = lerp(c[0], c[4], d[0]);
    e01 = lerp(c[1], c[5], d[0]);
    e10 = lerp(c[2], c[6], d[0]);
    e11 = lerp(c[3], c[7], d[0]);
    e0 = lerp(e00, e10, d[1]);
    e1 = lerp(e01, e11, d[1]);
    v = lerp(e0, e1, d[2]);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // expected result of a query at the current settings
  function automatic interp_res_t predict_interp(logic [31:0] px, py, pz);
    interp_res_t r;
    int n[3], lo[3], hi[3], st, s, idx;
    logic signed [63:0] d[3];
    logic signed [63:0] c[4][8];
    logic [31:0] p[3];
    p[0] = px; p[1] = py; p[2] = pz;
    n[0] = dim_n(pgti_pkg::DIM_X_LSB); n[1] = dim_n(pgti_pkg::DIM_Y_LSB);
    n[2] = dim_n(pgti_pkg::DIM_Z_LSB);
    st = 0;
    for (int a = 0; a < 3; a++) begin
      s = map_coord($signed({{32{p[a][31]}}, p[a]}) - org[a], inv_sp[a], n[a],
                    lo[a], hi[a], d[a]);
      if (s > st) st = s;
    end
    r.st = pgti_pkg::status_t'(st);
    r.fx = 0; r.fy = 0; r.fz = 0; r.en = 0;
    if (st == 2) return r;
    for (int k = 0; k < 8; k++) begin
      idx = (((k & 4) ? hi[0] : lo[0]) * n[1] + ((k & 2) ? hi[1] : lo[1])) * n[2]
            + ((k & 1) ? hi[2] : lo[2]);
      for (int ch = 0; ch < 3; ch++) c[ch][k] = frc[idx][ch];
      c[3][k] = eng[idx];
    end
    r.fx = trilerp(c[0], d);
    r.fy = trilerp(c[1], d);
    r.fz = trilerp(c[2], d);
    r.en = trilerp(c[3], d);
    return r;
  endfunction

  // true when a query reads only entries that have been loaded
  function automatic bit corners_loaded(logic [31:0] px, py, pz);
    int n[3], lo[3], hi[3], st, s, idx;
    logic signed [63:0] d[3];
    logic [31:0] p[3];
    p[0] = px; p[1] = py; p[2] = pz;
    n[0] = dim_n(pgti_pkg::DIM_X_LSB); n[1] = dim_n(pgti_pkg::DIM_Y_LSB);
    n[2] = dim_n(pgti_pkg::DIM_Z_LSB);
    st = 0;
    for (int a = 0; a < 3; a++) begin
      s = map_coord($signed({{32{p[a][31]}}, p[a]}) - org[a], inv_sp[a], n[a],
                    lo[a], hi[a], d[a]);
      if (s > st) st = s;
    end
    if (st == 2) return 1;
    for (int k = 0; k < 8; k++) begin
      idx = (((k & 4) ? hi[0] : lo[0]) * n[1] + ((k & 2) ? hi[1] : lo[1])) * n[2]
            + ((k & 1) ? hi[2] : lo[2]);
      if (!written[idx]) return 0;
    end
    return 1;
  endfunction

  // true when every corner that a query could read has been loaded
  function automatic bit grid_full();
    int tot;
    tot = dim_n(pgti_pkg::DIM_X_LSB) * dim_n(pgti_pkg::DIM_Y_LSB) *
          dim_n(pgti_pkg::DIM_Z_LSB);
    for (int i = 0; i < tot; i++) if (!written[i]) return 0;
    return 1;
  endfunction

  task automatic write_reg(pgti_pkg::cfg_idx_t ix, logic [31:0] v);
    cfg_index <= ix;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (ix)
      pgti_pkg::REG_INV_X, pgti_pkg::REG_INV_Y, pgti_pkg::REG_INV_Z: inv_sp[ix] = v;
      pgti_pkg::REG_OFF_X: org[0] = $signed(v);
      pgti_pkg::REG_OFF_Y: org[1] = $signed(v);
      pgti_pkg::REG_OFF_Z: org[2] = $signed(v);
      pgti_pkg::REG_DIMS: dims = v[17:0];
      pgti_pkg::REG_PERIODIC: wrap = v[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_word(grid_word_t w);
    interp_res_t e;
    while (($urandom_range(0, 99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_cmd <= w.cmd;
    in_entry_index <= w.idx;
    in_load_force_x <= w.lfx; in_load_force_y <= w.lfy;
    in_load_force_z <= w.lfz; in_load_energy <= w.len;
    in_pos_x <= w.px; in_pos_y <= w.py; in_pos_z <= w.pz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_words++;
    if (w.cmd == pgti_pkg::CMD_LOAD) begin
      if (int'(w.idx) < DEPTH) begin
        frc[w.idx][0] = w.lfx; frc[w.idx][1] = w.lfy; frc[w.idx][2] = w.lfz;
        eng[w.idx] = w.len; written[w.idx] = 1;
      end
    end else begin
      e = predict_interp(w.px, w.py, w.pz);
      if (w.has_exp && e.st != w.exp_st) begin
        errors++;
        if (mism++ < 10)
          $display("table row status %0d, predictor gives %0d", w.exp_st, e.st);
      end
      pending_q.push_back(e);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  task automatic fill_grid();
    grid_word_t w;
    int tot;
    tot = dim_n(pgti_pkg::DIM_X_LSB) * dim_n(pgti_pkg::DIM_Y_LSB) *
          dim_n(pgti_pkg::DIM_Z_LSB);
    for (int i = 0; i < tot; i++) begin
      w = '{cmd: pgti_pkg::CMD_LOAD, idx: i[14:0], lfx: $urandom, lfy: $urandom,
            lfz: $urandom, len: $urandom, px: $urandom, py: $urandom, pz: $urandom,
            has_exp: 0, exp_st: pgti_pkg::ST_OK};
      if ($urandom_range(0, 3) != 0) begin
        w.lfx = $signed(w.lfx) >>> 8; w.len = $signed(w.len) >>> 8;
      end
      send_word(w);
    end
  endtask

  function automatic grid_word_t rand_query();
    grid_word_t w;
    w = '{cmd: pgti_pkg::CMD_QUERY, idx: 15'($urandom), lfx: $urandom, lfy: $urandom,
          lfz: $urandom, len: $urandom, px: $urandom, py: $urandom, pz: $urandom,
          has_exp: 0, exp_st: pgti_pkg::ST_OK};
    // mostly positions near the grid
    if ($urandom_range(0, 4) != 0) begin
      w.px = 32'(org[0] + $urandom_range(0, 9 << 16) - (1 << 16));
      w.py = 32'(org[1] + $urandom_range(0, 9 << 16) - (1 << 16));
      w.pz = 32'(org[2] + $urandom_range(0, 9 << 16) - (1 << 16));
    end
    return w;
  endfunction

  // result checker
  always @(posedge clk) begin
    interp_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_res++;
      if (out_status == pgti_pkg::ST_CLAMP) n_clamp++;
      if (out_status == pgti_pkg::ST_OUTSIDE) n_out++;
      if (pending_q.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected result word");
      end else begin
        e = pending_q.pop_front();
        if (e.fx !== out_force_x || e.fy !== out_force_y || e.fz !== out_force_z ||
            e.en !== out_energy_out || e.st !== out_status) begin
          errors++;
          if (mism++ < 10)
            $display("mismatch exp %h %h %h %h st%0d got %h %h %h %h st%0d",
                     e.fx, e.fy, e.fz, e.en, e.st, out_force_x, out_force_y,
                     out_force_z, out_energy_out, out_status);
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= idle_pct);

  grid_word_t dir_tbl[$];

  initial begin
    grid_word_t w;
    int nq;
    rst_n = 0; in_valid = 0; out_ready = 0; cfg_valid = 0;
    in_cmd = 0; in_entry_index = 0; cfg_index = pgti_pkg::REG_INV_X; cfg_data = 0;
    in_load_force_x = 0; in_load_force_y = 0; in_load_force_z = 0; in_load_energy = 0;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    errors = 0; mism = 0; n_res = 0; n_words = 0; n_clamp = 0; n_out = 0;
    idle_pct = 7;
    for (int a = 0; a < 3; a++) begin
      inv_sp[a] = pgti_pkg::INV_RESET; org[a] = 0;
    end
    dims = pgti_pkg::DIMS_RESET; wrap = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // small 4x3x2 grid for the directed part
    write_reg(pgti_pkg::REG_DIMS,
              (4 << pgti_pkg::DIM_X_LSB) | (3 << pgti_pkg::DIM_Y_LSB) | 2);
    fill_grid();
    // extreme values at corner entries 0 and 7, and a load at the last index
    send_word('{pgti_pkg::CMD_LOAD, 15'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                32'h0, 0, 0, 0, 0, pgti_pkg::ST_OK});
    send_word('{pgti_pkg::CMD_LOAD, 15'd7, 32'h80000000, 32'h7FFFFFFF, 32'h1,
                32'h7FFFFFFF, 0, 0, 0, 0, pgti_pkg::ST_OK});
    send_word('{pgti_pkg::CMD_LOAD, 15'h7FFF, 32'h5, 32'h5, 32'h5, 32'h5, 0, 0, 0, 0,
                pgti_pkg::ST_OK});
    dir_tbl = '{
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, pgti_pkg::ST_OK},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 1,
        pgti_pkg::ST_OK},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h1FFFF, 32'h1FFFF, 32'hFFFF, 1,
        pgti_pkg::ST_OK},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 32'h8000, 32'h8000, 1,
        pgti_pkg::ST_CLAMP},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h0, 1,
        pgti_pkg::ST_CLAMP},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h0, 32'h0, 1,
        pgti_pkg::ST_OUTSIDE},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h30000, 32'h0, 32'h0, 1,
        pgti_pkg::ST_OUTSIDE},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h10000, 1,
        pgti_pkg::ST_OUTSIDE},
      '{pgti_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 32'h2C000, 32'h18000, 32'h4000, 0,
        pgti_pkg::ST_OK}
    };
    foreach (dir_tbl[i]) send_word(dir_tbl[i]);
    drain();
    // periodic wrap on the same grid, negative and huge positions
    write_reg(pgti_pkg::REG_PERIODIC, 1);
    foreach (dir_tbl[i]) begin
      w = dir_tbl[i]; w.has_exp = 0;
      send_word(w);
    end
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: dims = 18'd0;                                   // zero counts act as 1
        1: dims = 18'h3FFFF;                               // counts above max
        default: dims = ($urandom_range(1, 4) << pgti_pkg::DIM_X_LSB) |
                        ($urandom_range(1, 4) << pgti_pkg::DIM_Y_LSB) |
                        $urandom_range(1, 4);
      endcase
      write_reg(pgti_pkg::REG_DIMS, dims);
      write_reg(pgti_pkg::REG_PERIODIC, (ph == 0 || ph == 3 || ph == 5) ? 1 : 0);
      for (int a = 0; a < 3; a++) begin
        write_reg(pgti_pkg::cfg_idx_t'(pgti_pkg::REG_INV_X + a),
                  ph == 1 ? 32'hFFFFFFFF : ph == 2 ? 32'h0 : $urandom_range(1 << 14, 1 << 18));
        write_reg(pgti_pkg::cfg_idx_t'(pgti_pkg::REG_OFF_X + a),
                  ph == 3 ? 32'h80000000 : ph == 4 ? 32'h7FFFFFFF : $urandom);
      end
      if (ph == 1) begin
        // full-size grid: load the low corner block, queries elsewhere are skipped
        for (int k = 0; k < 8; k++) begin
          w = rand_query();
          w.cmd = pgti_pkg::CMD_LOAD;
          w.idx = 15'((k >> 2) * NMAX * NMAX + ((k >> 1) & 1) * NMAX + (k & 1));
          send_word(w);
        end
      end else if (!grid_full()) fill_grid();
      idle_pct = (ph == 3) ? 0 : 7;
      nq = (ph == 1) ? 20 : 50;
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          w = rand_query();
          w.cmd = pgti_pkg::CMD_LOAD;
          w.idx = (ph == 1) ? 15'($urandom_range(0, DEPTH - 1)) : w.idx;
          if (ph == 1 || int'(w.idx) >= DEPTH ||
              int'(w.idx) < dim_n(pgti_pkg::DIM_X_LSB) * dim_n(pgti_pkg::DIM_Y_LSB) *
                            dim_n(pgti_pkg::DIM_Z_LSB))
            send_word(w);
        end else begin
          w = rand_query();
          if (corners_loaded(w.px, w.py, w.pz)) send_word(w);
        end
      end
      drain();
    end

    $display("%0d words sent, %0d results checked (%0d clamped, %0d outside grid)",
             n_words, n_res, n_clamp, n_out);
    $display("covered clamp and periodic modes, zero and oversized grid counts");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
src/pgti_pkg.sv
src/pgti_mul.sv
src/periodic_grid_trilinear_interp.sv
dv/tb_periodic_grid_trilinear_interp.sv
